// File: sv/text_console_writer_assert.svh
// Assertion macros used by the console writer checker.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled while reset is high.
`define TCW_ASSERT_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("text console writer check failed");

// Next-cycle implication, sampled on clock and disabled while reset is high.
`define TCW_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("text console writer check failed");

`endif

// File: sv/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_DATA_W = 4;
   localparam int CELL_W     = 16;
   localparam int OFFSET_W   = 11;

   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_SET_POS = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;
   localparam logic [1:0] OP_READ    = 2'd3;

   localparam logic [1:0] CSR_FOREGROUND = 2'd0;
   localparam logic [1:0] CSR_BACKGROUND = 2'd1;
   localparam logic [1:0] CSR_CURSOR_EN  = 2'd2;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [3:0]        FG_RESET   = 4'h7;
   localparam logic [3:0]        BG_RESET   = 4'h0;
   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

   // Cursor update selects.
   localparam logic [2:0] CUR_HOLD   = 3'd0;
   localparam logic [2:0] CUR_CHAR   = 3'd1;
   localparam logic [2:0] CUR_DIV    = 3'd2;
   localparam logic [2:0] CUR_CLEAR  = 3'd3;
   localparam logic [2:0] CUR_SCROLL = 3'd4;

   // Pending result selects.
   localparam logic [1:0] PEND_HOLD   = 2'd0;
   localparam logic [1:0] PEND_NONE   = 2'd1;
   localparam logic [1:0] PEND_REPORT = 2'd2;
   localparam logic [1:0] PEND_CELL   = 2'd3;

   typedef struct packed {
      logic       capture;
      logic       gate_update;
      logic       stop_clear;
      logic [2:0] cur_sel;
      logic [1:0] pend_sel;
      logic       sweep_step;
      logic       sweep_copy;
      logic       sweep_blank_const;
      logic       div_start;
      logic       read_issue;
      logic       emit;
   } tcw_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       gated;
      logic       scroll_need;
      logic       offset_zero;
      logic       sweep_last;
      logic       out_free;
   } tcw_sts_type;

endpackage

// File: sv/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/tcw_ctrl.sv
// Sequencer of the text console writer: decodes each word and steps the datapath.
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  tcw_sts_type sts,
   output tcw_cmd_type cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EXEC   = 4'd1;
   localparam logic [3:0] S_SWEEP  = 4'd2;
   localparam logic [3:0] S_DRAIN  = 4'd3;
   localparam logic [3:0] S_CHAR   = 4'd4;
   localparam logic [3:0] S_DIVSET = 4'd6;
   localparam logic [3:0] S_READ   = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   localparam logic [1:0] K_INIT   = 2'd0;
   localparam logic [1:0] K_CLEAR  = 2'd1;
   localparam logic [1:0] K_SCROLL = 2'd2;

   logic [3:0] state_ff, state_in;
   logic [1:0] kind_ff, kind_in;
   logic [3:0] finish_state;

   // A finished word goes straight to the output register when it is free.
   assign finish_state = sts.out_free ? S_IDLE : S_DONE;
   assign req_ready    = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      kind_in  = kind_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            case (sts.op)
               OP_WRITE: begin
                  if (sts.gated) begin
                     cmd.gate_update = 1'b1;
                     cmd.pend_sel    = PEND_NONE;
                     cmd.emit        = sts.out_free;
                     state_in        = finish_state;
                  end else if (sts.scroll_need) begin
                     cmd.cur_sel = CUR_SCROLL;
                     kind_in     = K_SCROLL;
                     state_in    = S_SWEEP;
                  end else begin
                     cmd.cur_sel  = CUR_CHAR;
                     cmd.pend_sel = PEND_REPORT;
                     cmd.emit     = sts.out_free;
                     state_in     = finish_state;
                  end
               end
               OP_SET_POS: begin
                  cmd.stop_clear = 1'b1;
                  if (sts.offset_zero) begin
                     cmd.pend_sel = PEND_NONE;
                     cmd.emit     = sts.out_free;
                     state_in     = finish_state;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIVSET;
                  end
               end
               OP_CLEAR: begin
                  cmd.stop_clear = 1'b1;
                  cmd.cur_sel    = CUR_CLEAR;
                  kind_in        = K_CLEAR;
                  state_in       = S_SWEEP;
               end
               OP_READ: begin
                  cmd.read_issue = 1'b1;
                  state_in       = S_READ;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SWEEP: begin
            cmd.sweep_step        = 1'b1;
            cmd.sweep_copy        = (kind_ff == K_SCROLL);
            cmd.sweep_blank_const = (kind_ff == K_INIT);
            if (sts.sweep_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            case (kind_ff)
               K_SCROLL: begin
                  state_in = S_CHAR;
               end
               K_CLEAR: begin
                  cmd.pend_sel = PEND_REPORT;
                  cmd.emit     = sts.out_free;
                  state_in     = finish_state;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_CHAR: begin
            cmd.cur_sel  = CUR_CHAR;
            cmd.pend_sel = PEND_REPORT;
            cmd.emit     = sts.out_free;
            state_in     = finish_state;
         end
         S_DIVSET: begin
            cmd.cur_sel  = CUR_DIV;
            cmd.pend_sel = PEND_NONE;
            cmd.emit     = sts.out_free;
            state_in     = finish_state;
         end
         S_READ: begin
            cmd.pend_sel = PEND_CELL;
            cmd.emit     = sts.out_free;
            state_in     = finish_state;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Reset starts with the pass that blanks the whole screen store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         kind_ff  <= K_INIT;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// File: sv/tcw_dp.sv
// Datapath of the text console writer: cursor, colors, screen store, sweep and divider.
module tcw_dp
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  req_tlast,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [RSP_DATA_W-1:0] rsp_data,
   input  tcw_cmd_type           cmd,
   output tcw_sts_type           sts
);

   localparam int CELLS      = COLUMNS * ROWS;
   localparam int COPY_CELLS = CELLS - COLUMNS;
   localparam int CAW        = $clog2(CELLS);
   localparam int XW         = $clog2(COLUMNS);
   localparam int YW         = $clog2(ROWS + 1);
   localparam int LW         = YW + XW + 12;
   localparam int MULT_W     = OFFSET_W + 1;
   localparam int PROD_W     = OFFSET_W + MULT_W;
   localparam int DIV_SHIFT  = OFFSET_W + $clog2(COLUMNS);
   // Rounded-up reciprocal of COLUMNS; the quotient is exact for every offset.
   localparam logic [MULT_W-1:0] DIV_MULT =
      MULT_W'(((64'd1 << DIV_SHIFT) + 64'(COLUMNS) - 64'd1) / 64'(COLUMNS));

   // Configuration.
   logic [3:0] fg_ff, bg_ff;
   logic       cen_ff;

   // Captured word.
   logic [1:0]          op_ff;
   logic [7:0]          ch_ff;
   logic                last_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [4:0]          nrow_ff;
   logic [6:0]          ncol_ff;
   logic [OFFSET_W-1:0] addr_ff;

   // Cursor and write gate.
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic          stopped_ff, stopped_in;

   // Pending result fields.
   logic [OFFSET_W-1:0] pend_reg_ff, pend_reg_in;
   logic                pend_wr_ff, pend_wr_in;
   logic [CELL_W-1:0]   pend_cell_ff, pend_cell_in;

   // Sweep engine: a read stage on cnt_ff and a write stage in the cycle after it.
   logic [CAW-1:0] cnt_ff;
   logic           wr_valid_ff;
   logic [CAW-1:0] wr_addr_ff;
   logic           wr_mem_ff;
   logic           wr_const_ff;
   logic           copy_ok;

   // Reciprocal division of the linear offset by COLUMNS.
   logic [OFFSET_W-1:0] div_quo_ff;
   logic [PROD_W-1:0]   div_prod;
   logic [OFFSET_W-1:0] div_rem;

   logic in_range_ff, addr_ok;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [7:0]        attr;
   logic [CELL_W-1:0] fill_cell;
   logic [LW-1:0]     lin;
   logic [XW:0]       x_inc;
   logic [XW+6:0]     x_ext;
   logic [YW+4:0]     y_ext;
   logic              printable;

   logic              ram_we, ram_re;
   logic [CAW-1:0]    ram_waddr, ram_raddr;
   logic [CELL_W-1:0] ram_wdata, ram_rdata;

   assign attr      = {bg_ff, fg_ff};
   assign fill_cell = {attr, CHAR_SPACE};
   assign lin       = LW'(y_ff) * LW'(COLUMNS) + LW'(x_ff);
   assign x_inc     = (XW + 1)'(x_ff) + (XW + 1)'(1);
   assign printable = (ch_ff != CHAR_CR) && (ch_ff != CHAR_LF);
   assign copy_ok   = int'(cnt_ff) < COPY_CELLS;
   assign addr_ok   = int'(addr_ff) < CELLS;

   assign div_prod = PROD_W'(offset_ff) * PROD_W'(DIV_MULT);
   assign div_rem  = offset_ff - div_quo_ff * OFFSET_W'(COLUMNS);

   always_comb begin
      sts.op          = op_ff;
      sts.gated       = stopped_ff || (ch_ff == CHAR_NUL);
      sts.scroll_need = int'(y_ff) >= ROWS;
      sts.offset_zero = (offset_ff == '0);
      sts.sweep_last  = (cnt_ff == CAW'(CELLS - 1));
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // Cursor update.
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      case (cmd.cur_sel)
         CUR_CHAR: begin
            if (ch_ff == CHAR_CR) begin
               x_in = '0;
            end else if (ch_ff == CHAR_LF) begin
               x_in = '0;
               y_in = y_ff + YW'(1);
            end else if (int'(x_inc) >= COLUMNS) begin
               x_in = '0;
               y_in = y_ff + YW'(1);
            end else begin
               x_in = x_inc[XW-1:0];
            end
         end
         CUR_SCROLL: begin
            y_in = YW'(ROWS - 1);
         end
         CUR_CLEAR: begin
            y_in = (int'(nrow_ff) > ROWS) ? YW'(ROWS) : YW'(nrow_ff);
            x_in = (int'(ncol_ff) >= COLUMNS) ? XW'(COLUMNS - 1) : XW'(ncol_ff);
         end
         CUR_DIV: begin
            y_in = (int'(div_quo_ff) > ROWS) ? YW'(ROWS) : YW'(div_quo_ff);
            x_in = div_rem[XW-1:0];
         end
         default: begin
            x_in = x_ff;
         end
      endcase
   end

   always_comb begin
      stopped_in = stopped_ff;
      if (cmd.stop_clear) begin
         stopped_in = 1'b0;
      end else if (cmd.gate_update) begin
         // A zero byte stops the call, and the last byte of a call releases it.
         stopped_in = !last_ff;
      end
   end

   always_comb begin
      pend_reg_in  = pend_reg_ff;
      pend_wr_in   = pend_wr_ff;
      pend_cell_in = pend_cell_ff;
      case (cmd.pend_sel)
         PEND_NONE: begin
            pend_reg_in  = '0;
            pend_wr_in   = 1'b0;
            pend_cell_in = '0;
         end
         PEND_REPORT: begin
            pend_reg_in  = cen_ff ? lin[OFFSET_W-1:0] : '0;
            pend_wr_in   = cen_ff;
            pend_cell_in = '0;
         end
         PEND_CELL: begin
            pend_reg_in  = '0;
            pend_wr_in   = 1'b0;
            pend_cell_in = in_range_ff ? ram_rdata : '0;
         end
         default: begin
            pend_reg_in = pend_reg_ff;
         end
      endcase
   end

   assign x_ext = (XW + 7)'(x_in);
   assign y_ext = (YW + 5)'(y_in);

   // Screen store ports.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = wr_addr_ff;
      ram_wdata = fill_cell;
      if (wr_valid_ff) begin
         ram_we = 1'b1;
         if (wr_mem_ff) begin
            ram_wdata = ram_rdata;
         end else if (wr_const_ff) begin
            ram_wdata = BLANK_CELL;
         end
      end else if (cmd.cur_sel == CUR_CHAR && printable) begin
         ram_we    = 1'b1;
         ram_waddr = lin[CAW-1:0];
         ram_wdata = {attr, ch_ff};
      end
   end

   always_comb begin
      ram_re    = 1'b0;
      ram_raddr = CAW'(int'(cnt_ff) + COLUMNS);
      if (cmd.read_issue) begin
         ram_re    = addr_ok;
         ram_raddr = CAW'(addr_ff);
      end else if (cmd.sweep_step && cmd.sweep_copy && copy_ok) begin
         ram_re = 1'b1;
      end
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff        <= FG_RESET;
         bg_ff        <= BG_RESET;
         cen_ff       <= 1'b1;
         x_ff         <= '0;
         y_ff         <= '0;
         stopped_ff   <= 1'b0;
         cnt_ff       <= '0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FOREGROUND: fg_ff  <= csr_wdata;
               CSR_BACKGROUND: bg_ff  <= csr_wdata;
               CSR_CURSOR_EN:  cen_ff <= csr_wdata[0];
               default: begin
                  cen_ff <= cen_ff;
               end
            endcase
         end
         x_ff        <= x_in;
         y_ff        <= y_in;
         stopped_ff  <= stopped_in;
         wr_valid_ff <= cmd.sweep_step;
         if (cmd.sweep_step) begin
            cnt_ff <= sts.sweep_last ? '0 : cnt_ff + CAW'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_tuser;
         ch_ff     <= req_tdata[7:0];
         last_ff   <= req_tlast;
         offset_ff <= req_tdata[18:8];
         nrow_ff   <= req_tdata[23:19];
         ncol_ff   <= req_tdata[30:24];
         addr_ff   <= req_tdata[41:31];
      end
      pend_reg_ff  <= pend_reg_in;
      pend_wr_ff   <= pend_wr_in;
      pend_cell_ff <= pend_cell_in;
      if (cmd.sweep_step) begin
         wr_addr_ff  <= cnt_ff;
         wr_mem_ff   <= cmd.sweep_copy && copy_ok;
         wr_const_ff <= cmd.sweep_blank_const;
      end
      if (cmd.div_start) begin
         div_quo_ff <= OFFSET_W'(div_prod >> DIV_SHIFT);
      end
      if (cmd.read_issue) begin
         in_range_ff <= addr_ok;
      end
      if (cmd.emit) begin
         rsp_data_ff <= {pend_cell_in, pend_wr_in, pend_reg_in, x_ext[6:0], y_ext[4:0]};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: sv/text_console_writer.sv
// Top level of the text console writer: sequencer plus datapath.
//
// A text screen of ROWS x COLUMNS 16-bit cells (character in the low byte,
// background and foreground nibbles above). Each request word carries an
// operation in req_tuser: write a character, set the cursor from a linear
// offset, clear the screen and place the cursor, or read one cell. Every
// request word gives exactly one response word with the cursor after the
// operation, the cursor register value if it was updated, and the cell read.
// Colors and the cursor enable are written through the csr_ port.
// Per word: a plain character, a control byte, an ignored byte or a zero
// offset is done in the execute state, a cell read passes S_READ, and a nonzero
// position set passes S_DIVSET (the row comes from a reciprocal multiplication
// by COLUMNS). A clear walks the cell RAM one cell per cycle, and a character
// that first has to scroll walks it the same way to copy the rows up.
// After reset the block blanks the store and holds req_tready low meanwhile;
// csr writes are taken at any time.
// The response sits in an output register: a stalled receiver holds it
// there, and the block still accepts and works on the next request word
// until that word's response is ready.
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // character[7:0], linear_offset[18:8], new_row[23:19],
   // new_column[30:24], cell_address[41:31], zero fill above
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]            req_tuser,
   // end_of_write
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cursor_row[4:0], cursor_column[11:5], cursor_register[22:12],
   // cursor_register_written[23], read_cell[39:24]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   tcw_cmd_type cmd;
   tcw_sts_type sts;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcw_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_data  (rsp_tdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// File: sv/tcw_checker.sv
// Port-level checks of the text console writer and their binding.
`include "text_console_writer_assert.svh"

module tcw_checker
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int ROW_LIMIT = ROWS;

   // A stalled response word must stay put.
   `TCW_ASSERT_NEXT(a_rsp_valid_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `TCW_ASSERT_NEXT(a_rsp_data_hold, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // The cursor register field is zero whenever it was not written.
   `TCW_ASSERT_IMPLY(a_reg_zero_unwritten, rsp_tvalid && !rsp_tdata[23], rsp_tdata[22:12] == 11'd0)

   // The store is being blanked right after reset, so nothing moves.
   `TCW_ASSERT_IMPLY(a_quiet_after_reset, $past(reset), !req_tready && !rsp_tvalid)

   // The reported cursor column stays on the screen, and the row at most one row below it.
   `TCW_ASSERT_IMPLY(a_cursor_range, rsp_tvalid, int'(rsp_tdata[11:5]) < COLUMNS && int'(rsp_tdata[4:0]) <= ROW_LIMIT)

endmodule

bind text_console_writer tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: sim/text_console_writer_test.sv
// Self-checking testbench of the text console writer.
module text_console_writer_test;
   import tcw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int CELLS       = COLUMNS * ROWS;
   localparam int QUIET_LIMIT = 20000;
   localparam int TAIL_CYCLES = 50;
   localparam int PHASE_WORDS = 325;

   // Request payload, lowest field last in the declaration.
   typedef struct packed {
      logic [10:0] cell_address;
      logic [6:0]  new_column;
      logic [4:0]  new_row;
      logic [10:0] linear_offset;
      logic [7:0]  character;
   } console_req_t;

   typedef struct packed {
      logic [15:0] read_cell;
      logic        cursor_written;
      logic [10:0] cursor_reg;
      logic [6:0]  cursor_column;
      logic [4:0]  cursor_row;
   } console_rsp_t;

   // Screen predictor plus the queue of responses it still expects.
   class screen_model;
      logic [15:0]  cells [CELLS];
      bit [6:0]     cur_col;
      bit [4:0]     cur_row;
      bit           stopped;
      bit [3:0]     fg;
      bit [3:0]     bg;
      bit           cursor_on;
      console_rsp_t expected_rsp [$];
      int           errors;
      int           words;
      int           scrolls;
      int           clears;
      int           reads;
      int           reports;

      function new();
         fg        = FG_RESET;
         bg        = BG_RESET;
         cursor_on = 1'b1;
         blank_screen();
      endfunction

      function logic [15:0] make_cell(logic [7:0] ch);
         return {bg, fg, ch};
      endfunction

      function void blank_screen();
         foreach (cells[i]) cells[i] = make_cell(CHAR_SPACE);
      endfunction

      function void write_register(logic [1:0] index, logic [3:0] value);
         case (index)
            CSR_FOREGROUND: fg = value;
            CSR_BACKGROUND: bg = value;
            CSR_CURSOR_EN:  cursor_on = value[0];
            default: ;
         endcase
      endfunction

      function logic [10:0] cursor_linear();
         return 11'(int'(cur_col) + int'(cur_row) * COLUMNS);
      endfunction

      function void scroll_up();
         for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
         for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = make_cell(CHAR_SPACE);
         scrolls++;
      endfunction

      function void report_cursor(ref console_rsp_t rsp);
         if (cursor_on) begin
            rsp.cursor_reg     = cursor_linear();
            rsp.cursor_written = 1'b1;
            reports++;
         end
      endfunction

      function void apply_request(logic [1:0] op, console_req_t req, logic last);
         console_rsp_t rsp;
         int           row_of_offset;
         rsp = '0;
         words++;
         case (op)
            OP_WRITE: begin
               if (stopped) begin
                  if (last) stopped = 1'b0;
               end else if (req.character == CHAR_NUL) begin
                  stopped = !last;
               end else begin
                  if (cur_row >= ROWS) begin
                     scroll_up();
                     cur_row = ROWS - 1;
                  end
                  report_cursor(rsp);
                  if (req.character == CHAR_CR) begin
                     cur_col = 0;
                  end else if (req.character == CHAR_LF) begin
                     cur_col = 0;
                     cur_row++;
                  end else begin
                     cells[int'(cur_row) * COLUMNS + int'(cur_col)] = make_cell(req.character);
                     cur_col++;
                     if (cur_col >= COLUMNS) begin
                        cur_col = 0;
                        cur_row++;
                     end
                  end
               end
            end
            OP_SET_POS: begin
               stopped = 1'b0;
               if (req.linear_offset != 0) begin
                  row_of_offset = int'(req.linear_offset) / COLUMNS;
                  cur_col = 7'(int'(req.linear_offset) % COLUMNS);
                  cur_row = (row_of_offset > ROWS) ? 5'(ROWS) : 5'(row_of_offset);
               end
            end
            OP_CLEAR: begin
               stopped = 1'b0;
               cur_row = (req.new_row > ROWS) ? 5'(ROWS) : req.new_row;
               cur_col = (req.new_column >= COLUMNS) ? 7'(COLUMNS - 1) : req.new_column;
               blank_screen();
               report_cursor(rsp);
               clears++;
            end
            default: begin
               reads++;
               if (req.cell_address < CELLS) rsp.read_cell = cells[req.cell_address];
            end
         endcase
         rsp.cursor_row    = cur_row;
         rsp.cursor_column = cur_col;
         expected_rsp.push_back(rsp);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_reply(console_rsp_t got);
         console_rsp_t want;
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: response word with nothing expected, actual %h", $time, got);
            return;
         end
         want = expected_rsp.pop_front();
         compare_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
         compare_field("cursor_column", 16'(want.cursor_column), 16'(got.cursor_column));
         compare_field("cursor_register", 16'(want.cursor_reg), 16'(got.cursor_reg));
         compare_field("cursor_register_written", 16'(want.cursor_written),
                       16'(got.cursor_written));
         compare_field("read_cell", want.read_cell, got.read_cell);
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = OP_WRITE;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [1:0]            csr_index  = CSR_FOREGROUND;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   screen_model screen = new();
   int          burst_left;
   int          stall_left;
   int          stall_mode;
   logic [7:0]  stall_pattern;
   int          quiet_cycles;
   int          settings_used = 1;

   text_console_writer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver: checks each accepted word, then picks ready from a random stall mode
   // that it redraws when its random run length has run out.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) screen.check_reply(rsp_tdata);
      if (stall_left == 0) begin
         stall_mode    = $urandom_range(0, 3);
         stall_left    = $urandom_range(20, 200);
         stall_pattern = 8'($urandom()) | 8'h01;
      end
      stall_left--;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: begin
            rsp_tready    <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
         end
         default: rsp_tready <= ($urandom_range(0, 15) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, no word accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL text_console_writer");
            $finish;
         end
      end
   end

   function automatic console_req_t noise_fields();
      logic [63:0] bits;
      bits = {$urandom(), $urandom()};
      return bits[41:0];
   endfunction

   task automatic send_word(input logic [1:0] op, input console_req_t req, input logic last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 6)) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(req);
      req_tuser  <= op;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      screen.apply_request(op, req, last);
      burst_left--;
   endtask

   task automatic put_char(input logic [7:0] ch, input logic last);
      console_req_t req;
      req = noise_fields();
      req.character = ch;
      send_word(OP_WRITE, req, last);
   endtask

   task automatic read_at(input logic [10:0] addr);
      console_req_t req;
      req = noise_fields();
      req.cell_address = addr;
      send_word(OP_READ, req, 1'($urandom_range(0, 1)));
   endtask

   task automatic move_to(input logic [10:0] offset);
      console_req_t req;
      req = noise_fields();
      req.linear_offset = offset;
      send_word(OP_SET_POS, req, 1'($urandom_range(0, 1)));
   endtask

   task automatic clear_to(input logic [4:0] row, input logic [6:0] col);
      console_req_t req;
      req = noise_fields();
      req.new_row    = row;
      req.new_column = col;
      send_word(OP_CLEAR, req, 1'($urandom_range(0, 1)));
   endtask

   // Mostly write calls of random text closed by end_of_write, mixed with
   // reads near the cursor and elsewhere, cursor moves and the odd clear.
   task automatic run_random(input int count);
      int         target;
      int         pick;
      int         len;
      logic [7:0] ch;
      target = screen.words + count;
      while (screen.words < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 68) begin
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(20, 90);
            for (int i = 0; i < len; i++) begin
               pick = $urandom_range(0, 99);
               if (pick < 3) ch = CHAR_NUL;
               else if (pick < 7) ch = CHAR_CR;
               else if (pick < 15) ch = CHAR_LF;
               else if (pick < 35) ch = 8'($urandom_range(1, 255));
               else ch = 8'($urandom_range(8'h20, 8'h7E));
               put_char(ch, i == len - 1);
            end
         end else if (pick < 82) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
               read_at(11'((int'(screen.cursor_linear()) + CELLS - $urandom_range(0, 100))
                           % CELLS));
            else if (pick < 6) read_at(11'($urandom_range(CELLS, 2047)));
            else read_at(11'($urandom_range(0, 2047)));
         end else if (pick < 95) begin
            move_to(($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 2047)));
         end else begin
            clear_to(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
         end
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (screen.expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic set_display(input logic [3:0] fg, input logic [3:0] bg, input logic cursor_on);
      logic [3:0] en_word;
      en_word = {3'($urandom()), cursor_on};
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_FOREGROUND;
      csr_wdata <= fg;
      @(posedge clock);
      csr_index <= CSR_BACKGROUND;
      csr_wdata <= bg;
      @(posedge clock);
      csr_index <= CSR_CURSOR_EN;
      csr_wdata <= en_word;
      @(posedge clock);
      csr_we <= 1'b0;
      screen.write_register(CSR_FOREGROUND, fg);
      screen.write_register(CSR_BACKGROUND, bg);
      screen.write_register(CSR_CURSOR_EN, en_word);
      settings_used++;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset colors.
      read_at(11'd0);
      read_at(11'd1999);
      read_at(11'd2047);
      put_char("H", 1'b0);
      put_char(8'hFF, 1'b0);
      put_char(CHAR_CR, 1'b0);
      put_char(CHAR_LF, 1'b1);
      read_at(11'd1);
      // A zero byte mutes the call up to its last word.
      put_char(CHAR_NUL, 1'b0);
      put_char("x", 1'b0);
      put_char("y", 1'b1);
      put_char(CHAR_NUL, 1'b1);
      move_to(11'd0);
      move_to(11'd79);
      put_char("W", 1'b1);
      // Offset 2047 lands one row below the screen, so the next character scrolls.
      move_to(11'd2047);
      put_char("S", 1'b1);
      read_at(11'd1967);
      put_char(CHAR_NUL, 1'b0);
      move_to(11'd1999);
      put_char("Z", 1'b1);
      put_char(CHAR_LF, 1'b1);
      read_at(11'd1919);
      put_char(CHAR_NUL, 1'b0);
      // Saturated clear position also overflows the 11-bit cursor register.
      clear_to(5'd31, 7'd127);
      read_at(11'd5);

      run_random(PHASE_WORDS);
      drain();
      set_display(4'hF, 4'hF, 1'b0);
      run_random(PHASE_WORDS);
      drain();
      set_display(4'h0, 4'h0, 1'b1);
      run_random(PHASE_WORDS);
      drain();
      set_display(4'($urandom()), 4'($urandom()), 1'b0);
      run_random(PHASE_WORDS);
      drain();
      set_display(4'($urandom()), 4'($urandom()), 1'b1);
      run_random(PHASE_WORDS);
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (screen.expected_rsp.size() != 0)
         $display("%0t: %0d expected responses never arrived", $time,
                  screen.expected_rsp.size());
      $display("Sent %0d request words: %0d scrolls, %0d clears, %0d cell reads,",
               screen.words, screen.scrolls, screen.clears, screen.reads);
      $display("%0d cursor register updates, over %0d color and cursor settings.",
               screen.reports, settings_used);
      if (screen.errors == 0 && screen.expected_rsp.size() == 0) begin
         $display("PASS text_console_writer");
      end else begin
         $display("FAIL text_console_writer");
      end
      $finish;
   end

endmodule
